>>> hw/rtl/ppe_pkg.sv
// ----------------------------------------------------------------------------
// ppe_pkg
// Shared types and constants of the perfect power exponent test.
// ----------------------------------------------------------------------------
package ppe_pkg;

	localparam int VALUE_W      = 31;
	localparam int MASK_W       = 31;
	localparam int EXP_W        = 6;
	localparam int ROOT_W       = 16;
	localparam int OPER_W       = 32;
	localparam int PROD_W       = 2 * OPER_W;
	localparam int BIT_W        = 5;
	localparam int MAX_EXPONENT = 32;
	localparam int RESET_MAX    = 4;

	localparam logic [ROOT_W-1:0] ROOT_BOUND = 16'd46341;
	localparam logic [OPER_W-1:0] SAT_VALUE  = 32'h8000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK_K,
		ST_POW,
		ST_ACC_WR,
		ST_SQ_WR,
		ST_SEARCH,
		ST_FINISH
	} ppe_state_t;

	typedef enum logic {
		MODE_BOUND,
		MODE_SEARCH
	} ppe_mode_t;

	typedef struct packed {
		logic req_valid;
		logic k_gt_limit;
		logic value_one;
		logic e_zero;
		logic e_lsb;
		logic e_one;
		logic acc_gt_v;
		logic acc_eq_v;
		logic lo_gt_hi;
		logic out_free;
	} ppe_status_t;

	typedef struct packed {
		logic in_ready;
		logic load_item;
		logic set_bit;
		logic next_k;
		logic load_base2;
		logic load_mid;
		logic issue_acc_mul;
		logic issue_sq_mul;
		logic write_acc;
		logic write_sq;
		logic shift_e;
		logic search_init;
		logic lo_up;
		logic hi_down;
		logic load_out;
	} ppe_cmd_t;

endpackage

>>> hw/rtl/ppe_ifs.sv
// ----------------------------------------------------------------------------
// ppe_ifs
// Valid/ready channels of the perfect power exponent test.
// ----------------------------------------------------------------------------
interface ppe_req_if;
	logic        valid;
	logic        ready;
	logic [30:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface ppe_rsp_if;
	logic        valid;
	logic        ready;
	logic [30:0] value_out;
	logic [30:0] power_mask;

	modport source (output valid, output value_out, output power_mask, input ready);
	modport sink (input valid, input value_out, input power_mask, output ready);
endinterface

interface ppe_cfg_if;
	logic       valid;
	logic       ready;
	logic [5:0] max_exponent;

	modport source (output valid, output max_exponent, input ready);
	modport sink (input valid, input max_exponent, output ready);
endinterface

>>> hw/rtl/ppe_datapath.sv
// ----------------------------------------------------------------------------
// ppe_datapath
// Registers, shared multiplier and compares of the perfect power test.
// ----------------------------------------------------------------------------
module ppe_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	ppe_req_if.sink              req,
	ppe_rsp_if.source            rsp,
	ppe_cfg_if.sink              cfg,
	input  ppe_pkg::ppe_cmd_t    cmd,
	output ppe_pkg::ppe_status_t status
);
	import ppe_pkg::*;

	logic [EXP_W-1:0]   max_q;
	logic [EXP_W-1:0]   limit_q;
	logic [EXP_W-1:0]   k_q;
	logic [EXP_W-1:0]   e_q;
	logic [VALUE_W-1:0] value_q;
	logic [MASK_W-1:0]  mask_q;
	logic [ROOT_W-1:0]  lo_q;
	logic [ROOT_W-1:0]  hi_q;
	logic [ROOT_W-1:0]  mid_q;
	logic [OPER_W-1:0]  acc_q;
	logic [OPER_W-1:0]  sq_q;
	logic [PROD_W-1:0]  prod_q;
	logic               out_valid_q;
	logic [VALUE_W-1:0] value_out_q;
	logic [MASK_W-1:0]  mask_out_q;

	logic [EXP_W-1:0]   limit_d;
	logic [ROOT_W:0]    mid_sum;
	logic [ROOT_W-1:0]  mid_d;
	logic [OPER_W-1:0]  mul_a;
	logic [OPER_W-1:0]  prod_sat;
	logic [BIT_W-1:0]   bit_idx;

	assign limit_d  = (max_q > EXP_W'(MAX_EXPONENT)) ? EXP_W'(MAX_EXPONENT) : max_q;
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_d    = mid_sum[ROOT_W:1];
	assign mul_a    = cmd.issue_acc_mul ? acc_q : sq_q;
	assign prod_sat = (|prod_q[PROD_W-1:OPER_W-1]) ? SAT_VALUE : prod_q[OPER_W-1:0];
	assign bit_idx  = BIT_W'(k_q - EXP_W'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= EXP_W'(RESET_MAX);
		end else if (cfg.valid) begin
			max_q <= cfg.max_exponent;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			value_q <= req.value;
			limit_q <= limit_d;
			k_q     <= EXP_W'(2);
			mask_q  <= '0;
		end else begin
			if (cmd.set_bit) begin
				mask_q[bit_idx] <= 1'b1;
			end
			if (cmd.next_k) begin
				k_q <= k_q + EXP_W'(1);
			end
		end
		if (cmd.load_base2) begin
			acc_q <= OPER_W'(1);
			sq_q  <= OPER_W'(2);
			e_q   <= k_q;
		end else if (cmd.load_mid) begin
			mid_q <= mid_d;
			acc_q <= OPER_W'(1);
			sq_q  <= OPER_W'(mid_d);
			e_q   <= k_q;
		end else begin
			if (cmd.write_acc) begin
				acc_q <= prod_sat;
			end
			if (cmd.write_sq) begin
				sq_q <= prod_sat;
			end
			if (cmd.shift_e) begin
				e_q <= e_q >> 1;
			end
		end
		if (cmd.issue_acc_mul || cmd.issue_sq_mul) begin
			prod_q <= mul_a * sq_q;
		end
		if (cmd.search_init) begin
			lo_q <= ROOT_W'(1);
			hi_q <= ROOT_BOUND;
		end else if (cmd.lo_up) begin
			lo_q <= mid_q + ROOT_W'(1);
		end else if (cmd.hi_down) begin
			hi_q <= mid_q - ROOT_W'(1);
		end
		if (cmd.load_out) begin
			value_out_q <= value_q;
			mask_out_q  <= mask_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign req.ready      = cmd.in_ready;
	assign cfg.ready      = 1'b1;
	assign rsp.valid      = out_valid_q;
	assign rsp.value_out  = value_out_q;
	assign rsp.power_mask = mask_out_q;

	always_comb begin
		status.req_valid  = req.valid;
		status.k_gt_limit = k_q > limit_q;
		status.value_one  = value_q == VALUE_W'(1);
		status.e_zero     = e_q == '0;
		status.e_lsb      = e_q[0];
		status.e_one      = e_q == EXP_W'(1);
		status.acc_gt_v   = acc_q > {1'b0, value_q};
		status.acc_eq_v   = acc_q == {1'b0, value_q};
		status.lo_gt_hi   = lo_q > hi_q;
		status.out_free   = !out_valid_q || rsp.ready;
	end

endmodule

>>> hw/rtl/ppe_ctrl.sv
// ----------------------------------------------------------------------------
// ppe_ctrl
// Sequencer over exponents, root search probes and powering steps.
// ----------------------------------------------------------------------------
module ppe_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ppe_pkg::ppe_status_t status,
	output ppe_pkg::ppe_cmd_t    cmd
);
	import ppe_pkg::*;

	ppe_state_t state_q, state_d;
	ppe_mode_t  mode_q, mode_d;
	logic       pow_done;

	assign pow_done = status.acc_gt_v || status.e_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MODE_BOUND;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		unique case (state_q)
			ST_IDLE: begin
				if (status.req_valid) begin
					state_d = ST_CHECK_K;
				end
			end
			ST_CHECK_K: begin
				if (status.k_gt_limit) begin
					state_d = ST_FINISH;
				end else if (!status.value_one) begin
					state_d = ST_POW;
					mode_d  = MODE_BOUND;
				end
			end
			ST_POW: begin
				if (pow_done) begin
					if (mode_q == MODE_BOUND) begin
						state_d = status.acc_gt_v ? ST_FINISH : ST_SEARCH;
						mode_d  = MODE_SEARCH;
					end else if (!status.acc_gt_v && status.acc_eq_v) begin
						state_d = ST_CHECK_K;
					end else begin
						state_d = ST_SEARCH;
					end
				end else if (status.e_lsb) begin
					state_d = ST_ACC_WR;
				end else begin
					state_d = ST_SQ_WR;
				end
			end
			ST_ACC_WR: begin
				state_d = status.e_one ? ST_POW : ST_SQ_WR;
			end
			ST_SQ_WR: begin
				state_d = ST_POW;
			end
			ST_SEARCH: begin
				state_d = status.lo_gt_hi ? ST_CHECK_K : ST_POW;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_ready  = 1'b1;
				cmd.load_item = status.req_valid;
			end
			ST_CHECK_K: begin
				if (!status.k_gt_limit) begin
					if (status.value_one) begin
						cmd.set_bit = 1'b1;
						cmd.next_k  = 1'b1;
					end else begin
						cmd.load_base2 = 1'b1;
					end
				end
			end
			ST_POW: begin
				if (pow_done) begin
					if (mode_q == MODE_BOUND) begin
						cmd.search_init = !status.acc_gt_v;
					end else if (status.acc_gt_v) begin
						cmd.hi_down = 1'b1;
					end else if (status.acc_eq_v) begin
						cmd.set_bit = 1'b1;
						cmd.next_k  = 1'b1;
					end else begin
						cmd.lo_up = 1'b1;
					end
				end else if (status.e_lsb) begin
					cmd.issue_acc_mul = 1'b1;
				end else begin
					cmd.issue_sq_mul = 1'b1;
				end
			end
			ST_ACC_WR: begin
				cmd.write_acc = 1'b1;
				if (status.e_one) begin
					cmd.shift_e = 1'b1;
				end else begin
					cmd.issue_sq_mul = 1'b1;
				end
			end
			ST_SQ_WR: begin
				cmd.write_sq = 1'b1;
				cmd.shift_e  = 1'b1;
			end
			ST_SEARCH: begin
				if (status.lo_gt_hi) begin
					cmd.next_k = 1'b1;
				end else begin
					cmd.load_mid = 1'b1;
				end
			end
			ST_FINISH: begin
				cmd.load_out = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> hw/rtl/perfect_power_exponent_test.sv
// ----------------------------------------------------------------------------
// perfect_power_exponent_test
// Tests a 31-bit number for being an exact k-th power, k = 2..max_exponent (at most 32).
// ----------------------------------------------------------------------------
// One word at a time: a number is taken only when the block is idle, and its
// result word (number echoed plus exponent mask) goes to an output register,
// so the next number can be taken while that result waits. For each exponent
// the block first checks 2^k against the number, stopping the scan there, then
// binary-searches the root over 1..46341 in at most 16 probes. Each probe raises
// the candidate to the k-th power by square-and-multiply on one shared 32x32
// multiplier, ending early once the power passes the number. The time an item
// takes is longest for large numbers with many exponents to test, and is set by
// the shared multiplier and the serial search.
// ----------------------------------------------------------------------------
module perfect_power_exponent_test (
	input logic       clk,
	input logic       arst_n,
	ppe_req_if.sink   req,
	ppe_rsp_if.source rsp,
	ppe_cfg_if.sink   cfg
);
	import ppe_pkg::*;

	ppe_cmd_t    cmd;
	ppe_status_t status;

	ppe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	ppe_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.status (status)
	);

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("input taken while a word is still in work");

	a_zero_no_power: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.value_out == 31'd0) |-> (rsp.power_mask == 31'd0))
		else $error("zero reported as a power");

	a_one_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.value_out == 31'd1)
		|-> (((rsp.power_mask + 31'd1) & rsp.power_mask) == 31'd0))
		else $error("mask for one is not a run of low bits");
`endif

endmodule
